@@ rtl/xymc_pkg.sv @@
`timescale 1ns / 1ps

package xymc_pkg;

    localparam int SIDE       = 16;
    localparam int SITE_W     = 4;
    localparam int ADDR_W     = 2 * SITE_W;
    localparam int DEPTH      = SIDE * SIDE;
    localparam int ANGLE_BITS = 16;
    localparam int ANGLE_W    = 16;
    localparam int RND_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_W      = 20;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = 19;
    localparam int COS_W      = 16;
    localparam int DE_W       = 33;
    localparam int DE_LO_W    = 17;
    localparam int X_W        = 49;
    localparam int Q_SHIFT    = 26;
    localparam int Q_W        = X_W - Q_SHIFT;
    localparam int EXP_W      = 17;
    localparam int EXP_N      = 12;
    localparam int EXP_LIMIT  = EXP_N * 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd2;

    localparam logic [CFG_W-1:0] RST_COUPLING = 16'd256;
    localparam logic [CFG_W-1:0] RST_INV_TEMP = 16'd102;
    localparam logic [CFG_W-1:0] RST_MAX_STEP = 16'd10430;

    typedef struct packed {
        logic [CFG_W-1:0] coupling;
        logic [CFG_W-1:0] inv_temperature;
        logic [CFG_W-1:0] max_step;
    } t_cfg;

    typedef struct packed {
        logic               accepted;
        logic [ANGLE_W-1:0] site_angle;
    } t_res;

    localparam logic [14:0] QCOS [0:64] = '{
        15'd16384, 15'd16379, 15'd16364, 15'd16340, 15'd16305, 15'd16261, 15'd16207,
        15'd16143, 15'd16069, 15'd15986, 15'd15893, 15'd15791, 15'd15679, 15'd15557,
        15'd15426, 15'd15286, 15'd15137, 15'd14978, 15'd14811, 15'd14635, 15'd14449,
        15'd14255, 15'd14053, 15'd13842, 15'd13623, 15'd13395, 15'd13160, 15'd12916,
        15'd12665, 15'd12406, 15'd12140, 15'd11866, 15'd11585, 15'd11297, 15'd11003,
        15'd10702, 15'd10394, 15'd10080, 15'd9760,  15'd9434,  15'd9102,  15'd8765,
        15'd8423,  15'd8076,  15'd7723,  15'd7366,  15'd7005,  15'd6639,  15'd6270,
        15'd5897,  15'd5520,  15'd5139,  15'd4756,  15'd4370,  15'd3981,  15'd3590,
        15'd3196,  15'd2801,  15'd2404,  15'd2006,  15'd1606,  15'd1205,  15'd804,
        15'd402,   15'd0
    };

    // Full-wave cosine in Q1.14 from the quarter-wave table by symmetry.
    function automatic logic signed [COS_W-1:0] cos_q14(input logic [7:0] idx);
        logic [5:0]       r;
        logic [6:0]       rr;
        logic [COS_W-1:0] a;
        logic [COS_W-1:0] b;
        r  = idx[5:0];
        rr = 7'd64 - {1'b0, r};
        a  = {1'b0, QCOS[r]};
        b  = {1'b0, QCOS[rr]};
        case (idx[7:6])
            2'd0:    cos_q14 = a;
            2'd1:    cos_q14 = -b;
            2'd2:    cos_q14 = -a;
            default: cos_q14 = b;
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
        case (n)
            4'd0:    exp_int = 17'd65536;
            4'd1:    exp_int = 17'd24109;
            4'd2:    exp_int = 17'd8869;
            4'd3:    exp_int = 17'd3263;
            4'd4:    exp_int = 17'd1200;
            4'd5:    exp_int = 17'd442;
            4'd6:    exp_int = 17'd162;
            4'd7:    exp_int = 17'd60;
            4'd8:    exp_int = 17'd22;
            4'd9:    exp_int = 17'd8;
            4'd10:   exp_int = 17'd3;
            4'd11:   exp_int = 17'd1;
            default: exp_int = 17'd0;
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] exp_frac(input logic [3:0] f);
        case (f)
            4'd0:    exp_frac = 17'd65536;
            4'd1:    exp_frac = 17'd61566;
            4'd2:    exp_frac = 17'd57835;
            4'd3:    exp_frac = 17'd54331;
            4'd4:    exp_frac = 17'd51039;
            4'd5:    exp_frac = 17'd47947;
            4'd6:    exp_frac = 17'd45042;
            4'd7:    exp_frac = 17'd42313;
            4'd8:    exp_frac = 17'd39750;
            4'd9:    exp_frac = 17'd37341;
            4'd10:   exp_frac = 17'd35079;
            4'd11:   exp_frac = 17'd32954;
            4'd12:   exp_frac = 17'd30957;
            4'd13:   exp_frac = 17'd29081;
            4'd14:   exp_frac = 17'd27319;
            default: exp_frac = 17'd25664;
        endcase
    endfunction

endpackage

@@ rtl/xymc_item_if.sv @@
`timescale 1ns / 1ps

interface xymc_item_if;
    import xymc_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [SITE_W-1:0] site_x;
    logic [SITE_W-1:0] site_y;
    logic [RND_W-1:0]  proposal_random;
    logic [RND_W-1:0]  accept_random;

    modport source (
        output valid, op, site_x, site_y, proposal_random, accept_random,
        input  ready
    );

    modport sink (
        input  valid, op, site_x, site_y, proposal_random, accept_random,
        output ready
    );
endinterface

@@ rtl/xymc_result_if.sv @@
`timescale 1ns / 1ps

interface xymc_result_if;
    import xymc_pkg::*;

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [ANGLE_W-1:0] site_angle;

    modport source (
        output valid, accepted, site_angle,
        input  ready
    );

    modport sink (
        input  valid, accepted, site_angle,
        output ready
    );
endinterface

@@ rtl/xymc_ram.sv @@
`timescale 1ns / 1ps

module xymc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/xymc_mul.sv @@
`timescale 1ns / 1ps

module xymc_mul (
    input  logic                                 i_clk,
    input  logic signed [xymc_pkg::MUL_W-1:0]    i_a,
    input  logic signed [xymc_pkg::MUL_W-1:0]    i_b,
    output logic signed [xymc_pkg::PROD_W-1:0]   o_p
);
    import xymc_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

@@ rtl/xymc_core.sv @@
`timescale 1ns / 1ps

module xymc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xymc_pkg::t_cfg   i_cfg,
    xymc_item_if.sink        i_item,
    input  logic             i_res_free,
    output logic             o_res_valid,
    output xymc_pkg::t_res   o_res
);
    import xymc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CTR, S_NEW, S_NB, S_DE, S_DEW, S_XLO, S_XHI, S_Q, S_W, S_FIN
    } t_state;

    t_state                    r_state;
    logic                      r_op;
    logic [SITE_W-1:0]         r_x;
    logic [SITE_W-1:0]         r_y;
    logic [RND_W-1:0]          r_pr;
    logic [RND_W-1:0]          r_ar;
    logic [ANGLE_BITS-1:0]     r_old;
    logic [ANGLE_BITS-1:0]     r_new;
    logic signed [SUM_W-1:0]   r_sum;
    logic [1:0]                r_nb;
    logic [DE_W-1:0]           r_de;
    logic [DE_W-1:0]           r_xlo;
    logic [Q_W-1:0]            r_q;
    logic                      r_acc;
    logic [DEPTH-1:0]          r_valid;
    logic                      r_rd_valid;

    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ANGLE_BITS-1:0]     ram_q;
    logic [ANGLE_BITS-1:0]     rd_angle;
    logic                      ram_we;
    logic [1:0]                nb_sel;
    logic [SITE_W-1:0]         xp;
    logic [SITE_W-1:0]         xm;
    logic [SITE_W-1:0]         yp;
    logic [SITE_W-1:0]         ym;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [ANGLE_BITS-1:0]     diff_old;
    logic [ANGLE_BITS-1:0]     diff_new;
    logic signed [COS_W-1:0]   cos_old;
    logic signed [COS_W-1:0]   cos_new;
    logic signed [COS_W:0]     bond_delta;
    logic                      de_nonpos;
    logic [X_W-1:0]            x_sum;
    logic [EXP_W-1:0]          w;
    logic                      leave_fin;

    xymc_ram #(
        .WIDTH (ANGLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_new),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    xymc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign xp = (r_x == SITE_W'(SIDE - 1)) ? '0 : r_x + 1'b1;
    assign xm = (r_x == '0) ? SITE_W'(SIDE - 1) : r_x - 1'b1;
    assign yp = (r_y == SITE_W'(SIDE - 1)) ? '0 : r_y + 1'b1;
    assign ym = (r_y == '0) ? SITE_W'(SIDE - 1) : r_y - 1'b1;

    assign nb_sel = (r_state == S_NB) ? r_nb + 2'd1 : 2'd0;

    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = {i_item.site_y, i_item.site_x};
        end else begin
            case (nb_sel)
                2'd0:    rd_addr = {r_y, xp};
                2'd1:    rd_addr = {r_y, xm};
                2'd2:    rd_addr = {yp, r_x};
                default: rd_addr = {ym, r_x};
            endcase
        end
    end

    // Sites never written still hold their reset angle of zero.
    assign rd_angle = r_rd_valid ? ram_q : '0;

    assign wr_addr   = {r_y, r_x};
    assign leave_fin = (r_state == S_FIN) && i_res_free;
    assign ram_we    = leave_fin && r_acc;

    assign diff_old   = r_old - rd_angle;
    assign diff_new   = r_new - rd_angle;
    assign cos_old    = cos_q14(diff_old[ANGLE_BITS-1 -: 8]);
    assign cos_new    = cos_q14(diff_new[ANGLE_BITS-1 -: 8]);
    assign bond_delta = {cos_old[COS_W-1], cos_old} - {cos_new[COS_W-1], cos_new};

    assign de_nonpos = prod[PROD_W-1] || (prod == '0);
    assign x_sum     = {prod[31:0], {DE_LO_W{1'b0}}} + {{(X_W - DE_W){1'b0}}, r_xlo};
    assign w         = prod[16 + EXP_W - 1:16];

    always_comb begin
        case (r_state)
            S_CTR: begin
                mul_a = {{(MUL_W - CFG_W){1'b0}}, i_cfg.max_step};
                mul_b = $signed({{(MUL_W - RND_W - 1){1'b0}}, r_pr, 1'b0})
                        - $signed(MUL_W'(65536));
            end
            S_DE: begin
                mul_a = {{(MUL_W - CFG_W){1'b0}}, i_cfg.coupling};
                mul_b = {{(MUL_W - SUM_W){r_sum[SUM_W-1]}}, r_sum};
            end
            S_DEW: begin
                mul_a = {{(MUL_W - DE_LO_W){1'b0}}, prod[DE_LO_W-1:0]};
                mul_b = {{(MUL_W - CFG_W){1'b0}}, i_cfg.inv_temperature};
            end
            S_XLO: begin
                mul_a = {{(MUL_W - DE_W + DE_LO_W){1'b0}}, r_de[DE_W-1:DE_LO_W]};
                mul_b = {{(MUL_W - CFG_W){1'b0}}, i_cfg.inv_temperature};
            end
            S_Q: begin
                mul_a = {{(MUL_W - EXP_W){1'b0}}, exp_int(r_q[7:4])};
                mul_b = {{(MUL_W - EXP_W){1'b0}}, exp_frac(r_q[3:0])};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            if (ram_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op    <= i_item.op;
                        r_x     <= i_item.site_x;
                        r_y     <= i_item.site_y;
                        r_pr    <= i_item.proposal_random;
                        r_ar    <= i_item.accept_random;
                        r_state <= S_CTR;
                    end
                end
                S_CTR: begin
                    r_old <= rd_angle;
                    r_acc <= 1'b0;
                    r_state <= r_op ? S_FIN : S_NEW;
                end
                S_NEW: begin
                    r_new   <= r_old + prod[16 + ANGLE_BITS - 1:16];
                    r_sum   <= '0;
                    r_nb    <= 2'd0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    r_sum <= r_sum + {{(SUM_W - COS_W - 1){bond_delta[COS_W]}}, bond_delta};
                    r_nb  <= r_nb + 2'd1;
                    if (r_nb == 2'd3) begin
                        r_state <= S_DE;
                    end
                end
                S_DE: begin
                    r_state <= S_DEW;
                end
                S_DEW: begin
                    if (de_nonpos) begin
                        r_acc   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_de    <= prod[DE_W-1:0];
                        r_state <= S_XLO;
                    end
                end
                S_XLO: begin
                    r_xlo   <= prod[DE_W-1:0];
                    r_state <= S_XHI;
                end
                S_XHI: begin
                    r_q     <= x_sum[X_W-1:Q_SHIFT];
                    r_state <= S_Q;
                end
                S_Q: begin
                    if (r_q >= Q_W'(EXP_LIMIT)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_W;
                    end
                end
                S_W: begin
                    r_acc   <= ({1'b0, r_ar} < w);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_res_valid      = leave_fin;
    assign o_res.accepted   = r_acc;
    assign o_res.site_angle = r_acc ? r_new : r_old;
endmodule

@@ rtl/xy_model_metropolis_update.sv @@
`timescale 1ns / 1ps

// XY model Metropolis update engine on a 16 by 16 periodic lattice of spin angles.
// Items enter on i_item (valid/ready). A trial item proposes a new angle for one site,
// forms the energy change against its four neighbors and keeps or restores the angle.
// A read item returns the stored angle of a site. Every item yields one beat on o_result
// with the accepted flag and the site angle after the item.
// Configuration registers (coupling, inverse temperature, largest step) are written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while no item
// is in progress, which the block does not enforce. A trial reads the site, forms the
// new angle, sums four neighbor bond terms, scales the energy change and forms the
// weight, ending early when the energy does not rise or the weight is zero; a read ends
// after the site read. One memory port serves five reads, one multiplier five products
// in turn; a new item is taken the cycle after a result loads the output register.
// Reset clears the whole lattice to zero at once and restores the register defaults.
// When the receiver stalls, the result waits in the output register; the next item is
// still accepted and runs until its own result is ready, then it waits for the slot.
module xy_model_metropolis_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [xymc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [xymc_pkg::CFG_W-1:0]       i_cfg_data,
    xymc_item_if.sink                        i_item,
    xymc_result_if.source                    o_result
);
    import xymc_pkg::*;

    t_cfg  r_cfg;
    logic  r_out_valid;
    t_res  r_out;
    logic  res_free;
    logic  res_valid;
    t_res  res;

    assign res_free = !r_out_valid || o_result.ready;

    xymc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (i_item),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coupling        <= RST_COUPLING;
            r_cfg.inv_temperature <= RST_INV_TEMP;
            r_cfg.max_step        <= RST_MAX_STEP;
            r_out_valid           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COUPLING: r_cfg.coupling        <= i_cfg_data;
                    CFG_INV_TEMP: r_cfg.inv_temperature <= i_cfg_data;
                    CFG_MAX_STEP: r_cfg.max_step        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.accepted   = r_out.accepted;
    assign o_result.site_angle = r_out.site_angle;
endmodule

@@ rtl/xymc_checker.sv @@
`timescale 1ns / 1ps

module xymc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_accepted,
    input logic [xymc_pkg::ANGLE_W-1:0]  i_out_angle
);
    import xymc_pkg::*;

    // After reset the block is empty and waiting for an item.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle and empty after reset");

    // An accepted item occupies the sequencer, so no further item is taken while it runs.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while previous item still in progress");

    // No result can appear in the cycle after an item is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_accepted) && $stable(i_out_angle)))
        else $error("stalled result beat changed or dropped");
endmodule

bind xy_model_metropolis_update xymc_checker u_xymc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_accepted (o_result.accepted),
    .i_out_angle    (o_result.site_angle)
);

@@ verif/xy_model_metropolis_update_tb.sv @@
`timescale 1ns / 1ps

module xy_model_metropolis_update_tb;
    import xymc_pkg::*;

    localparam int LAT_TRIAL       = 14;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int EXP_SCALE_SHIFT = 26;
    localparam int PHASE_ITEMS     = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        OP_TRIAL = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef struct {
        t_op               op;
        logic [SITE_W-1:0] x;
        logic [SITE_W-1:0] y;
        logic [RND_W-1:0]  step_rnd;
        logic [RND_W-1:0]  acc_rnd;
    } t_spin_item;

    localparam int QUARTER_COS [65] = '{
        16384, 16379, 16364, 16340, 16305, 16261, 16207, 16143,
        16069, 15986, 15893, 15791, 15679, 15557, 15426, 15286,
        15137, 14978, 14811, 14635, 14449, 14255, 14053, 13842,
        13623, 13395, 13160, 12916, 12665, 12406, 12140, 11866,
        11585, 11297, 11003, 10702, 10394, 10080, 9760, 9434,
        9102, 8765, 8423, 8076, 7723, 7366, 7005, 6639,
        6270, 5897, 5520, 5139, 4756, 4370, 3981, 3590,
        3196, 2801, 2404, 2006, 1606, 1205, 804, 402,
        0
    };

    localparam longint EXP_WHOLE [12] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
    };

    localparam longint EXP_PART [16] = '{
        65536, 61566, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    xymc_item_if   item_if ();
    xymc_result_if result_if ();

    xy_model_metropolis_update u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    logic [ANGLE_W-1:0] spin_model [DEPTH];
    logic [CFG_W-1:0]   mdl_coupling;
    logic [CFG_W-1:0]   mdl_inv_temp;
    logic [CFG_W-1:0]   mdl_max_step;
    t_res               expected_q [$];

    int errors      = 0;
    int cycle_count = 0;
    int beat_count  = 0;
    int rx_stall    = 0;
    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;
    bit rx_hold     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int cos_bond(logic [ANGLE_W-1:0] diff);
        logic [7:0] idx;
        int         r;
        idx = diff[ANGLE_W-1 -: 8];
        r   = int'(idx[5:0]);
        case (idx[7:6])
            2'd0:    return QUARTER_COS[r];
            2'd1:    return -QUARTER_COS[64 - r];
            2'd2:    return -QUARTER_COS[r];
            default: return QUARTER_COS[64 - r];
        endcase
    endfunction

    function automatic int bond_sum_at(int x, int y);
        logic [ANGLE_W-1:0] a;
        a = spin_model[y * SIDE + x];
        return cos_bond(a - spin_model[y * SIDE + (x + 1) % SIDE]) +
               cos_bond(a - spin_model[y * SIDE + (x + SIDE - 1) % SIDE]) +
               cos_bond(a - spin_model[((y + 1) % SIDE) * SIDE + x]) +
               cos_bond(a - spin_model[((y + SIDE - 1) % SIDE) * SIDE + x]);
    endfunction

    function automatic t_res predict_spin_item(t_spin_item it);
        int                 idx;
        int                 old_sum;
        int                 new_sum;
        logic [ANGLE_W-1:0] old_a;
        longint             prod;
        longint             delta;
        longint             de;
        longint             q;
        longint             n;
        longint             w;
        t_res               r;
        idx        = int'(it.y) * SIDE + int'(it.x);
        r.accepted = 1'b0;
        if (it.op == OP_TRIAL) begin
            old_a   = spin_model[idx];
            old_sum = bond_sum_at(int'(it.x), int'(it.y));
            prod    = longint'(mdl_max_step) * (2 * longint'(it.step_rnd) - 65536);
            delta   = prod >>> 16;
            spin_model[idx] = old_a + delta[ANGLE_W-1:0];
            new_sum = bond_sum_at(int'(it.x), int'(it.y));
            de      = longint'(mdl_coupling) * longint'(old_sum - new_sum);
            if (de <= 0) begin
                r.accepted = 1'b1;
            end else begin
                q = (de * longint'(mdl_inv_temp)) >>> EXP_SCALE_SHIFT;
                n = q >>> 4;
                w = (n < 12) ? ((EXP_WHOLE[n] * EXP_PART[q % 16]) >>> 16) : 0;
                r.accepted = (longint'(it.acc_rnd) < w);
            end
            if (!r.accepted) begin
                spin_model[idx] = old_a;
            end
        end
        r.site_angle = spin_model[idx];
        return r;
    endfunction

    function automatic t_spin_item make_item(t_op op, int x, int y, int pr, int ar);
        t_spin_item it;
        it.op       = op;
        it.x        = SITE_W'(x);
        it.y        = SITE_W'(y);
        it.step_rnd = RND_W'(pr);
        it.acc_rnd  = RND_W'(ar);
        return it;
    endfunction

    function automatic t_spin_item random_item(bit clustered, int cx, int cy);
        t_spin_item it;
        it.op = ($urandom_range(0, 9) < 7) ? OP_TRIAL : OP_READ;
        if (clustered) begin
            it.x = SITE_W'((cx + $urandom_range(0, 2)) % SIDE);
            it.y = SITE_W'((cy + $urandom_range(0, 2)) % SIDE);
        end else begin
            it.x = SITE_W'($urandom_range(0, SIDE - 1));
            it.y = SITE_W'($urandom_range(0, SIDE - 1));
        end
        case ($urandom_range(0, 15))
            0:       it.step_rnd = '0;
            1:       it.step_rnd = '1;
            default: it.step_rnd = RND_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 15))
            0:       it.acc_rnd = '0;
            1:       it.acc_rnd = '1;
            default: it.acc_rnd = RND_W'($urandom_range(0, 65535));
        endcase
        return it;
    endfunction

    // The valid line is left high on return so that the next beat can follow at once.
    task automatic send_item(t_spin_item it);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.op              <= it.op;
        item_if.site_x          <= it.x;
        item_if.site_y          <= it.y;
        item_if.proposal_random <= it.step_rnd;
        item_if.accept_random   <= it.acc_rnd;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        expected_q.push_back(predict_spin_item(it));
    endtask

    task automatic wait_results();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COUPLING: mdl_coupling = data;
            CFG_INV_TEMP: mdl_inv_temp = data;
            CFG_MAX_STEP: mdl_max_step = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_W-1:0] c, logic [CFG_W-1:0] t, logic [CFG_W-1:0] s);
        cfg_write(CFG_COUPLING, c);
        cfg_write(CFG_INV_TEMP, t);
        cfg_write(CFG_MAX_STEP, s);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(int count);
        int         cx;
        int         cy;
        t_spin_item it;
        cx = 0;
        cy = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                cx = $urandom_range(0, SIDE - 1);
                cy = $urandom_range(0, SIDE - 1);
            end
            it = random_item($urandom_range(0, 1), cx, cy);
            send_item(it);
        end
        wait_results();
    endtask

    task automatic test_reset_reads();
        send_item(make_item(OP_READ, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 15, 15, 65535, 65535));
        send_item(make_item(OP_READ, 15, 0, 0, 65535));
        send_item(make_item(OP_READ, 0, 15, 65535, 0));
        wait_results();
    endtask

    task automatic test_zero_step();
        set_config(RST_COUPLING, RST_INV_TEMP, 16'd0);
        send_item(make_item(OP_TRIAL, 5, 5, 0, 65535));
        send_item(make_item(OP_TRIAL, 5, 5, 65535, 65535));
        send_item(make_item(OP_TRIAL, 6, 5, 12345, 0));
        wait_results();
    endtask

    task automatic test_step_extremes();
        set_config(RST_COUPLING, RST_INV_TEMP, 16'd32768);
        send_item(make_item(OP_TRIAL, 0, 0, 0, 65535));
        send_item(make_item(OP_TRIAL, 15, 15, 65535, 0));
        send_item(make_item(OP_TRIAL, 1, 0, 32768, 65535));
        send_item(make_item(OP_TRIAL, 0, 15, 1, 40000));
        send_item(make_item(OP_READ, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 15, 15, 0, 0));
        wait_results();
    endtask

    task automatic test_zero_coupling();
        set_config(16'd0, 16'd65535, 16'd32768);
        send_item(make_item(OP_TRIAL, 0, 1, 3000, 65535));
        send_item(make_item(OP_TRIAL, 15, 0, 60000, 65535));
        wait_results();
    endtask

    task automatic test_zero_inv_temp();
        set_config(16'd65535, 16'd0, 16'd20000);
        send_item(make_item(OP_TRIAL, 0, 0, 9000, 65535));
        send_item(make_item(OP_TRIAL, 1, 1, 50000, 65535));
        wait_results();
    endtask

    task automatic test_cold_lattice();
        set_config(16'd65535, 16'd65535, 16'd32768);
        send_item(make_item(OP_TRIAL, 0, 0, 20000, 0));
        send_item(make_item(OP_TRIAL, 15, 15, 45000, 0));
        send_item(make_item(OP_TRIAL, 1, 1, 0, 0));
        wait_results();
    endtask

    task automatic test_spare_index();
        cfg_write(CFG_SPARE, 16'hFFFF);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_item(make_item(OP_TRIAL, 0, 1, 7000, 100));
        send_item(make_item(OP_READ, 0, 1, 0, 0));
        wait_results();
    endtask

    task automatic test_random_mix();
        set_config(RST_COUPLING, RST_INV_TEMP, RST_MAX_STEP);
        run_random_phase(PHASE_ITEMS);
        set_config(16'd256, 16'd1024, 16'd10430);
        run_random_phase(PHASE_ITEMS);
        set_config(16'd512, 16'd4096, 16'd4000);
        run_random_phase(PHASE_ITEMS);
        for (int i = 0; i < 2; i++) begin
            set_config(CFG_W'($urandom_range(0, 1024)), CFG_W'($urandom_range(0, 8192)),
                       CFG_W'($urandom_range(0, 32768)));
            run_random_phase(PHASE_ITEMS);
        end
        set_config(16'd65535, 16'd65535, 16'd32768);
        run_random_phase(PHASE_ITEMS / 2);
        set_config(16'd0, 16'd0, 16'd0);
        run_random_phase(PHASE_ITEMS / 2);
    endtask

    task automatic test_backpressure();
        set_config(RST_COUPLING, RST_INV_TEMP, RST_MAX_STEP);
        hold_req = 1'b1;
        run_random_phase(40);
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        set_config(16'd300, 16'd512, 16'd16000);
        run_random_phase(PHASE_ITEMS);
    endtask

    initial begin
        forever begin
            wait (hold_req);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
            hold_req = 1'b0;
        end
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                result_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                result_if.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(1, 8) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: beat %0d unexpected, accepted %0b angle %0d", $time,
                         beat_count, result_if.accepted, result_if.site_angle);
            end else begin
                want = expected_q.pop_front();
                if (result_if.accepted !== want.accepted) begin
                    errors++;
                    $display("%0t: beat %0d accepted expected %0b actual %0b", $time,
                             beat_count, want.accepted, result_if.accepted);
                end
                if (result_if.site_angle !== want.site_angle) begin
                    errors++;
                    $display("%0t: beat %0d site_angle expected %0d actual %0d", $time,
                             beat_count, want.site_angle, result_if.site_angle);
                end
            end
            beat_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = '0;
        i_cfg_data              = '0;
        item_if.valid           = 1'b0;
        item_if.op              = 1'b0;
        item_if.site_x          = '0;
        item_if.site_y          = '0;
        item_if.proposal_random = '0;
        item_if.accept_random   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            spin_model[i] = '0;
        end
        mdl_coupling = RST_COUPLING;
        mdl_inv_temp = RST_INV_TEMP;
        mdl_max_step = RST_MAX_STEP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_zero_step();
        test_step_extremes();
        test_zero_coupling();
        test_zero_inv_temp();
        test_cold_lattice();
        test_spare_index();
        test_random_mix();
        test_backpressure();
        test_full_rate();

        repeat (2 * LAT_TRIAL) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
